// ===== src/block_map_walker_macros.svh =====
// Assertion macros shared by the block map walker RTL.
`ifndef BLOCK_MAP_WALKER_MACROS_SVH
`define BLOCK_MAP_WALKER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BMW_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BMW_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/bmw_pkg.sv =====
// Types and constants for the block map walker.
package bmw_pkg;

    localparam int MAX_LOG_BLOCK_SIZE = 2;
    // Largest block size shift that still keeps every index in ten bits.
    localparam int SHIFT_CAP = (MAX_LOG_BLOCK_SIZE < 2) ? MAX_LOG_BLOCK_SIZE : 2;

    localparam logic [31:0] DIRECT_COUNT = 32'd12;
    localparam logic [3:0]  SLOT_SINGLE  = 4'd12;
    localparam logic [3:0]  SLOT_DOUBLE  = 4'd13;
    localparam logic [3:0]  SLOT_TRIPLE  = 4'd14;
    localparam logic [3:0]  SLOT_COUNT   = 4'd15;
    localparam int          BASE_SHIFT   = 8;

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_XLATE = 2'd1,
        OP_WORD  = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FAIL  = 2'd2,
        ST_TURN  = 2'd3
    } status_t;

    typedef enum logic {
        KIND_READ = 1'b0,
        KIND_DONE = 1'b1
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [31:0] request_block;
        logic [9:0]  request_index;
        logic [31:0] mapped_block;
        status_t     status;
    } result_t;

endpackage

// ===== src/block_map_walker.sv =====
// Block map walker: inode block pointer table and logical to physical lookup.
// An item is taken into an input register, worked on in one pass of short logic,
// and its result (if any) lands in an output register; one item per cycle is
// sustained, set by the single input-to-result pass, while m_tready keeps the
// output free. Pointer loads and unused ops give no result. A walk through
// indirect blocks issues one read request per level; each returned word is sent
// in as an op 2 item, and out-of-turn items are answered with status 3.
`include "block_map_walker_macros.svh"

module block_map_walker (
    input  logic          clk,
    input  logic          rst_n,
    // Input stream.
    input  logic          s_tvalid,
    output logic          s_tready,
    // slot[3:0], pointer_value[35:4], logical_block[67:36], fetched_word[99:68]
    input  logic [103:0]  s_tdata,
    // op[1:0], fetch_failed[2]
    input  logic [2:0]    s_tuser,
    // Result stream.
    output logic          m_tvalid,
    input  logic          m_tready,
    // request_block[31:0], request_index[41:32], mapped_block[73:42], status[75:74]
    output logic [79:0]   m_tdata,
    // kind[0]
    output logic [0:0]    m_tuser,
    // Configuration port.
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [2:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);

    // Configuration.
    logic [1:0] log_block_size_reg;

    // Input register.
    logic        in_valid_reg;
    logic [1:0]  in_op_reg;
    logic [3:0]  in_slot_reg;
    logic [31:0] in_pointer_reg;
    logic [31:0] in_logical_reg;
    logic [31:0] in_word_reg;
    logic        in_failed_reg;

    // Walk state.
    logic [31:0] pointer_table_reg [15];
    logic        walk_busy_reg;
    logic        walk_busy_next;
    logic [1:0]  levels_left_reg;
    logic [1:0]  levels_left_next;
    logic [9:0]  mid_index_reg;
    logic [9:0]  mid_index_next;
    logic [9:0]  inner_index_reg;
    logic [9:0]  inner_index_next;

    // Output register.
    logic              out_valid_reg;
    bmw_pkg::result_t  out_reg;
    bmw_pkg::result_t  res;
    logic              has_res;
    logic              advance;

    // Index arithmetic.
    logic [1:0]  eff_shift;
    logic [4:0]  sh;
    logic [4:0]  sh2;
    logic [4:0]  sh3;
    logic [31:0] mask;
    logic [31:0] single_end;
    logic [31:0] double_end;
    logic [31:0] triple_end;
    logic [31:0] idx_single;
    logic [31:0] idx_double;
    logic [31:0] idx_triple;

    assign pready = 1'b1;
    assign prdata = paddr[2] ? 32'd0 : {30'd0, log_block_size_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            log_block_size_reg <= 2'd0;
        end
        else if (psel && penable && pwrite && pready && !paddr[2])
        begin
            log_block_size_reg <= pwdata[1:0];
        end
    end

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_op_reg      <= s_tuser[1:0];
            in_failed_reg  <= s_tuser[2];
            in_slot_reg    <= s_tdata[3:0];
            in_pointer_reg <= s_tdata[35:4];
            in_logical_reg <= s_tdata[67:36];
            in_word_reg    <= s_tdata[99:68];
        end
    end

    // Shift is saturated so that every index stays within ten bits.
    always_comb
    begin
        if (log_block_size_reg > 2'(bmw_pkg::SHIFT_CAP))
        begin
            eff_shift = 2'(bmw_pkg::SHIFT_CAP);
        end
        else
        begin
            eff_shift = log_block_size_reg;
        end
    end

    assign sh         = 5'(bmw_pkg::BASE_SHIFT) + {3'd0, eff_shift};
    assign sh2        = sh << 1;
    assign sh3        = sh2 + sh;
    assign mask       = (32'd1 << sh) - 32'd1;
    assign single_end = bmw_pkg::DIRECT_COUNT + (32'd1 << sh);
    assign double_end = single_end + (32'd1 << sh2);
    assign triple_end = double_end + (32'd1 << sh3);
    assign idx_single = in_logical_reg - bmw_pkg::DIRECT_COUNT;
    assign idx_double = in_logical_reg - single_end;
    assign idx_triple = in_logical_reg - double_end;

    always_comb
    begin
        res              = '0;
        has_res          = 1'b0;
        walk_busy_next   = walk_busy_reg;
        levels_left_next = levels_left_reg;
        mid_index_next   = mid_index_reg;
        inner_index_next = inner_index_reg;
        unique case (in_op_reg)
            bmw_pkg::OP_XLATE:
            begin
                has_res = 1'b1;
                res.kind = bmw_pkg::KIND_DONE;
                priority if (walk_busy_reg)
                begin
                    res.status = bmw_pkg::ST_TURN;
                end
                else if (in_logical_reg < bmw_pkg::DIRECT_COUNT)
                begin
                    res.mapped_block = pointer_table_reg[in_logical_reg[3:0]];
                end
                else if (in_logical_reg < single_end)
                begin
                    if (pointer_table_reg[bmw_pkg::SLOT_SINGLE] != 32'd0)
                    begin
                        res.kind          = bmw_pkg::KIND_READ;
                        res.request_block = pointer_table_reg[bmw_pkg::SLOT_SINGLE];
                        res.request_index = idx_single[9:0];
                        walk_busy_next    = 1'b1;
                        levels_left_next  = 2'd0;
                    end
                end
                else if (in_logical_reg < double_end)
                begin
                    if (pointer_table_reg[bmw_pkg::SLOT_DOUBLE] != 32'd0)
                    begin
                        res.kind          = bmw_pkg::KIND_READ;
                        res.request_block = pointer_table_reg[bmw_pkg::SLOT_DOUBLE];
                        res.request_index = 10'(idx_double >> sh);
                        walk_busy_next    = 1'b1;
                        levels_left_next  = 2'd1;
                        inner_index_next  = 10'(idx_double & mask);
                    end
                end
                else if (in_logical_reg < triple_end)
                begin
                    if (pointer_table_reg[bmw_pkg::SLOT_TRIPLE] != 32'd0)
                    begin
                        res.kind          = bmw_pkg::KIND_READ;
                        res.request_block = pointer_table_reg[bmw_pkg::SLOT_TRIPLE];
                        res.request_index = 10'(idx_triple >> sh2);
                        walk_busy_next    = 1'b1;
                        levels_left_next  = 2'd2;
                        mid_index_next    = 10'((idx_triple >> sh) & mask);
                        inner_index_next  = 10'(idx_triple & mask);
                    end
                end
                else
                begin
                    res.status = bmw_pkg::ST_RANGE;
                end
            end
            bmw_pkg::OP_WORD:
            begin
                has_res  = 1'b1;
                res.kind = bmw_pkg::KIND_DONE;
                priority if (!walk_busy_reg)
                begin
                    res.status = bmw_pkg::ST_TURN;
                end
                else if (in_failed_reg)
                begin
                    res.status       = bmw_pkg::ST_FAIL;
                    walk_busy_next   = 1'b0;
                    levels_left_next = 2'd0;
                end
                else if (levels_left_reg == 2'd0)
                begin
                    res.mapped_block = in_word_reg;
                    walk_busy_next   = 1'b0;
                end
                else if (in_word_reg == 32'd0)
                begin
                    // A zero pointer in an indirect block is a hole.
                    walk_busy_next   = 1'b0;
                    levels_left_next = 2'd0;
                end
                else
                begin
                    res.kind          = bmw_pkg::KIND_READ;
                    res.request_block = in_word_reg;
                    if (levels_left_reg == 2'd2)
                    begin
                        res.request_index = mid_index_reg;
                        levels_left_next  = 2'd1;
                    end
                    else
                    begin
                        res.request_index = inner_index_reg;
                        levels_left_next  = 2'd0;
                    end
                end
            end
            default:
            begin
                has_res = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (advance && (in_op_reg == bmw_pkg::OP_LOAD) && (in_slot_reg < bmw_pkg::SLOT_COUNT))
        begin
            pointer_table_reg[in_slot_reg] <= in_pointer_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            walk_busy_reg   <= 1'b0;
            levels_left_reg <= 2'd0;
            mid_index_reg   <= 10'd0;
            inner_index_reg <= 10'd0;
        end
        else if (advance)
        begin
            walk_busy_reg   <= walk_busy_next;
            levels_left_reg <= levels_left_next;
            mid_index_reg   <= mid_index_next;
            inner_index_reg <= inner_index_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && has_res)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && has_res)
        begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.kind;
    assign m_tdata  = {4'd0, out_reg.status, out_reg.mapped_block, out_reg.request_index,
                       out_reg.request_block};

    `BMW_ASSERT_SAME(a_idle_no_levels, !walk_busy_reg, levels_left_reg == 2'd0, "levels left while idle")
    `BMW_ASSERT_SAME(a_read_clean, m_tvalid && (out_reg.kind == bmw_pkg::KIND_READ), (out_reg.status == bmw_pkg::ST_OK) && (out_reg.mapped_block == 32'd0), "read request carries a result")
    `BMW_ASSERT_SAME(a_error_no_phys, m_tvalid && (out_reg.status != bmw_pkg::ST_OK), (out_reg.mapped_block == 32'd0) && (out_reg.kind == bmw_pkg::KIND_DONE), "error result carries a block")
    `BMW_ASSERT_NEXT(a_read_sets_busy, advance && has_res && (res.kind == bmw_pkg::KIND_READ), walk_busy_reg, "read request without a walk")

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the inode block map walker: stream stimulus, APB setup, scoreboard.
module tb;
    import bmw_pkg::*;

    localparam logic [1:0]  OP_UNUSED          = 2'd3;
    localparam logic [2:0]  REG_LOG_BLOCK_SIZE = 3'd0;
    localparam int unsigned STALL_LIMIT        = 2000;
    localparam int unsigned LONG_HOLD          = 300;
    localparam int unsigned PHASE_ITEMS        = 260;

    // Tracks the pointer table and walk state, and holds the results still owed by the block.
    class block_map_tracker;
        logic [31:0] slot_ptr [15];
        bit          walking = 1'b0;
        logic [1:0]  levels_left = 2'd0;
        logic [9:0]  mid_idx = 10'd0;
        logic [9:0]  inner_idx = 10'd0;
        logic [1:0]  log_size = 2'd0;
        result_t     owed_results [$];
        int unsigned mismatches = 0;
        int unsigned checked = 0;

        function int unsigned index_shift();
            return BASE_SHIFT + ((log_size > SHIFT_CAP) ? SHIFT_CAP : log_size);
        endfunction

        // First logical block of each level: direct, single, double, triple, out of range.
        function logic [63:0] region_start(int level);
            logic [63:0] start;
            int unsigned sh;
            start = 64'd0;
            sh = index_shift();
            if (level >= 1)
                start = {32'd0, DIRECT_COUNT};
            for (int i = 1; i < level; i++)
                start += 64'd1 << (i * sh);
            return start;
        endfunction

        function void push(kind_t kind, logic [31:0] blk, logic [9:0] idx,
                           logic [31:0] phys, status_t st);
            result_t r;
            r.kind = kind;
            r.request_block = blk;
            r.request_index = idx;
            r.mapped_block = phys;
            r.status = st;
            owed_results.push_back(r);
        endfunction

        function void finish_walk(logic [31:0] phys, status_t st);
            walking = 1'b0;
            levels_left = 2'd0;
            push(KIND_DONE, 32'd0, 10'd0, phys, st);
        endfunction

        // A zero pointer in the top slot is a hole and ends the walk right away.
        function void begin_walk(logic [3:0] slot, logic [1:0] levels, logic [9:0] idx);
            if (slot_ptr[slot] == 32'd0)
                finish_walk(32'd0, ST_OK);
            else
            begin
                walking = 1'b1;
                levels_left = levels;
                push(KIND_READ, slot_ptr[slot], idx, 32'd0, ST_OK);
            end
        endfunction

        function void translate(logic [31:0] lblk);
            logic [63:0] lg;
            logic [63:0] off;
            logic [63:0] mask;
            logic [63:0] t;
            int unsigned sh;
            sh = index_shift();
            mask = (64'd1 << sh) - 64'd1;
            lg = {32'd0, lblk};
            if (lg < region_start(1))
                finish_walk(slot_ptr[lblk[3:0]], ST_OK);
            else if (lg < region_start(2))
            begin
                off = lg - region_start(1);
                begin_walk(SLOT_SINGLE, 2'd0, off[9:0]);
            end
            else if (lg < region_start(3))
            begin
                off = lg - region_start(2);
                inner_idx = off[9:0] & mask[9:0];
                t = off >> sh;
                begin_walk(SLOT_DOUBLE, 2'd1, t[9:0]);
            end
            else if (lg < region_start(4))
            begin
                off = lg - region_start(3);
                inner_idx = off[9:0] & mask[9:0];
                t = off >> sh;
                mid_idx = t[9:0] & mask[9:0];
                t = off >> (2 * sh);
                begin_walk(SLOT_TRIPLE, 2'd2, t[9:0]);
            end
            else
                push(KIND_DONE, 32'd0, 10'd0, 32'd0, ST_RANGE);
        endfunction

        function void take_word(logic [31:0] word, logic failed);
            logic [9:0] idx;
            if (!walking)
                push(KIND_DONE, 32'd0, 10'd0, 32'd0, ST_TURN);
            else if (failed)
                finish_walk(32'd0, ST_FAIL);
            else if (levels_left == 2'd0)
                finish_walk(word, ST_OK);
            else if (word == 32'd0)
                finish_walk(32'd0, ST_OK);
            else
            begin
                if (levels_left == 2'd2)
                begin
                    idx = mid_idx;
                    levels_left = 2'd1;
                end
                else
                begin
                    idx = inner_idx;
                    levels_left = 2'd0;
                end
                push(KIND_READ, word, idx, 32'd0, ST_OK);
            end
        endfunction

        function void note_request(logic [1:0] op, logic [3:0] slot, logic [31:0] ptr,
                                   logic [31:0] lblk, logic [31:0] word, logic failed);
            case (op)
                OP_LOAD:
                    if (slot < SLOT_COUNT)
                        slot_ptr[slot] = ptr;
                OP_XLATE:
                    if (walking)
                        push(KIND_DONE, 32'd0, 10'd0, 32'd0, ST_TURN);
                    else
                        translate(lblk);
                OP_WORD:
                    take_word(word, failed);
                default:
                    ;
            endcase
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got)
            begin
                $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
                mismatches++;
            end
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (owed_results.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, got kind %0d block %h index %0d phys %h status %0d",
                         $time, got.kind, got.request_block, got.request_index,
                         got.mapped_block, got.status);
                mismatches++;
                return;
            end
            want = owed_results.pop_front();
            checked++;
            compare_field("kind", 32'(want.kind), 32'(got.kind));
            compare_field("request_block", want.request_block, got.request_block);
            compare_field("request_index", 32'(want.request_index), 32'(got.request_index));
            compare_field("mapped_block", want.mapped_block, got.mapped_block);
            compare_field("status", 32'(want.status), 32'(got.status));
        endfunction
    endclass

    logic         clk = 1'b0;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [103:0] s_tdata;
    logic [2:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [79:0]  m_tdata;
    logic [0:0]   m_tuser;
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [2:0]   paddr;
    logic [31:0]  pwdata;
    logic [31:0]  prdata;
    logic         pready;

    block_map_tracker map_check = new();
    int unsigned      n_sent = 0;
    bit               hold_long = 1'b0;
    bit               no_idle = 1'b0;

    block_map_walker u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Called at a falling edge; returns at the falling edge after the request is taken.
    task automatic send_item(input logic [1:0] op, input logic [3:0] slot,
                             input logic [31:0] ptr, input logic [31:0] lblk,
                             input logic [31:0] word, input logic failed);
        int unsigned gap;
        gap = no_idle ? 0 : $urandom_range(0, 3);
        if (gap > 0)
        begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tdata = {4'd0, word, lblk, ptr, slot};
        s_tuser = {failed, op};
        s_tvalid = 1'b1;
        do @(posedge clk); while (!s_tready);
        map_check.note_request(op, slot, ptr, lblk, word, failed);
        n_sent++;
        @(negedge clk);
    endtask

    task automatic send_load(input logic [3:0] slot, input logic [31:0] value);
        send_item(OP_LOAD, slot, value, $urandom(), $urandom(), 1'($urandom_range(0, 1)));
    endtask

    task automatic send_xlate(input logic [31:0] lblk);
        send_item(OP_XLATE, 4'($urandom_range(0, 15)), $urandom(), lblk, $urandom(),
                  1'($urandom_range(0, 1)));
    endtask

    task automatic send_word(input logic [31:0] word, input logic failed);
        send_item(OP_WORD, 4'($urandom_range(0, 15)), $urandom(), $urandom(), word, failed);
    endtask

    task automatic send_noise();
        send_item(2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)), $urandom(),
                  $urandom(), $urandom(), 1'($urandom_range(0, 1)));
    endtask

    function automatic logic [31:0] random_pointer();
        int unsigned roll;
        roll = $urandom_range(0, 19);
        if (roll < 3)
            return 32'd0;
        if (roll == 3)
            return 32'hFFFF_FFFF;
        return $urandom();
    endfunction

    // Picks a level at random, then either end of it or a point inside.
    function automatic logic [31:0] pick_logical();
        int unsigned region;
        int unsigned corner;
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] v;
        region = $urandom_range(0, 4);
        lo = map_check.region_start(region);
        hi = (region == 4) ? 64'hFFFF_FFFF : map_check.region_start(region + 1) - 64'd1;
        corner = $urandom_range(0, 3);
        if (corner == 0)
            v = lo;
        else if (corner == 1)
            v = hi;
        else
            v = lo + ({32'd0, $urandom()} % (hi - lo + 64'd1));
        return v[31:0];
    endfunction

    // One translate followed by returned words until the walk is over.
    task automatic run_walk();
        int unsigned roll;
        send_xlate(pick_logical());
        while (map_check.walking)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 5)
                send_noise();
            else if (roll < 15)
                send_word($urandom(), 1'b1);
            else if (roll < 25)
                send_word(32'd0, 1'b0);
            else
                send_word(random_pointer(), 1'b0);
        end
    endtask

    task automatic random_phase(input int unsigned count);
        int unsigned stop;
        int unsigned roll;
        stop = n_sent + count;
        while (n_sent < stop)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 10)
                send_load(4'($urandom_range(0, 15)), random_pointer());
            else if (roll < 70)
                run_walk();
            else
                send_noise();
        end
        // Leave no walk open across a register change.
        if (map_check.walking)
            send_word($urandom(), 1'b1);
    endtask

    task automatic settle_block();
        s_tvalid = 1'b0;
        while (map_check.owed_results.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    // Writes the block size register and reads it back.
    task automatic write_log_size(input logic [1:0] value);
        psel = 1'b1;
        pwrite = 1'b1;
        penable = 1'b0;
        paddr = REG_LOG_BLOCK_SIZE;
        pwdata = {30'd0, value};
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        map_check.log_size = value;
        @(negedge clk);
        pwrite = 1'b0;
        penable = 1'b0;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata !== {30'd0, value})
        begin
            $display("%0t: log_block_size readback mismatch, expected %h, got %h",
                     $time, {30'd0, value}, prdata);
            map_check.mismatches++;
        end
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
    endtask

    // Result side: random ready gaps, plus one long hold-off on request.
    initial
    begin
        int unsigned gap;
        m_tready = 1'b0;
        forever
        begin
            if (hold_long)
            begin
                m_tready = 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
                hold_long = 1'b0;
            end
            gap = no_idle ? 0 : $urandom_range(0, 3);
            if (gap > 0)
            begin
                m_tready = 1'b0;
                repeat (gap) @(negedge clk);
            end
            m_tready = 1'b1;
            do @(posedge clk); while (!m_tvalid);
            @(negedge clk);
        end
    end

    always @(posedge clk)
    begin
        result_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.kind = kind_t'(m_tuser[0]);
            got.request_block = m_tdata[31:0];
            got.request_index = m_tdata[41:32];
            got.mapped_block = m_tdata[73:42];
            got.status = status_t'(m_tdata[75:74]);
            map_check.check_result(got);
        end
    end

    initial
    begin
        int unsigned quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
        $display("Some tests failed");
        $finish;
    end

    initial
    begin
        logic [63:0] lstart;
        logic [1:0]  plan [4];
        plan = '{2'd2, 2'd1, 2'd3, 2'd0};
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        write_log_size(2'd0);

        // Fill the whole table first so that no lookup reads an empty slot.
        for (int i = 0; i < SLOT_COUNT; i++)
            send_load(4'(i), (i == 0) ? 32'd0 : (i == 11) ? 32'hFFFF_FFFF : ($urandom() | 32'd1));
        send_load(SLOT_COUNT, $urandom());
        send_item(OP_UNUSED, 4'($urandom_range(0, 15)), $urandom(), $urandom(), $urandom(),
                  1'b1);
        send_xlate(32'd0);
        send_xlate(DIRECT_COUNT - 32'd1);
        send_word($urandom(), 1'b0);
        send_xlate(32'hFFFF_FFFF);
        send_xlate(DIRECT_COUNT);
        send_xlate(32'd5);
        send_load(4'd3, $urandom());
        send_word(32'hFFFF_FFFF, 1'b0);
        lstart = map_check.region_start(3);
        send_xlate(lstart[31:0]);
        send_word(32'd1, 1'b0);
        send_word(32'd0, 1'b0);
        lstart = lstart - 64'd1;
        send_xlate(lstart[31:0]);
        send_word($urandom(), 1'b1);

        for (int k = 0; k < 4; k++)
        begin
            settle_block();
            write_log_size(plan[k]);
            if (k == 1)
                hold_long = 1'b1;
            no_idle = (k == 2);
            random_phase(PHASE_ITEMS / 2);
            no_idle = 1'b0;
            random_phase(PHASE_ITEMS / 2);
        end

        s_tvalid = 1'b0;
        while (map_check.owed_results.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (map_check.owed_results.size() != 0)
            $display("%0t: %0d expected results never arrived", $time,
                     map_check.owed_results.size());
        $display("Sent %0d requests and checked %0d results across block size settings 0 to 3,",
                 n_sent, map_check.checked);
        $display("covering direct, indirect, hole, range, read failure and out-of-turn cases.");
        if (map_check.mismatches == 0 && map_check.owed_results.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
